// File: rtl/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    localparam int unsigned DPOS_W = 10;
    localparam int unsigned BIDX_W = 9;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_EMPTY  = 3'd1,
        KIND_EOF    = 3'd2,
        KIND_CSUM   = 3'd3,
        KIND_FORMAT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        LM_START  = 2'd0,
        LM_SKIP   = 2'd1,
        LM_RECORD = 2'd2,
        LM_HALT   = 2'd3
    } t_line_mode;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2
    } t_back_state;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [7:0]  count;
        logic [7:0]  csum;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ihex_queue.sv
`default_nettype none

module ihex_queue
    import ihex_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_job          i_job,
    input  wire logic          i_pop,
    output t_job               o_job,
    output t_queue_status      o_status
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign o_job          = r_slot[r_rd_ptr];

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ihex_front.sv
`default_nettype none

module ihex_front
    import ihex_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic [7:0]                      i_ch,
    input  wire t_queue_status                   i_q_status,
    input  wire logic                            i_store_busy,
    output logic                                 o_full,
    output logic                                 o_q_push,
    output t_job                                 o_job,
    output logic                                 o_wr_en,
    output logic [$clog2(RECORD_BYTES)-1:0]      o_wr_addr,
    output logic [7:0]                           o_wr_data
);

    localparam int unsigned AW = $clog2(RECORD_BYTES);
    localparam logic [BIDX_W-1:0] MAX_LEN = BIDX_W'(RECORD_BYTES);

    t_line_mode        r_mode;
    t_line_mode        n_mode;
    logic [DPOS_W-1:0] r_dpos;
    logic [DPOS_W-1:0] n_dpos;
    logic [3:0]        r_nib;
    logic [3:0]        n_nib;
    logic [7:0]        r_len;
    logic [7:0]        n_len;
    logic [15:0]       r_off;
    logic [15:0]       n_off;
    logic [7:0]        r_type;
    logic [7:0]        n_type;
    logic [7:0]        r_sum;
    logic [7:0]        n_sum;
    logic [15:0]       r_upper;
    logic [15:0]       n_upper;
    logic [7:0]        r_ub0;
    logic [7:0]        n_ub0;
    logic [7:0]        r_ub1;
    logic [7:0]        n_ub1;

    logic              w_acc;
    logic              w_eol;
    logic              w_colon;
    logic [3:0]        w_digit;
    logic [7:0]        w_byte;
    logic [BIDX_W-1:0] w_idx;
    logic [BIDX_W-1:0] w_data_end;
    logic              w_in_data;
    logic              w_byte_done;
    logic              w_len_bad;
    logic              w_is_cks;
    logic [7:0]        w_calc;
    logic [BIDX_W-1:0] w_didx;

    assign w_eol      = (i_ch == CH_LF) || (i_ch == CH_CR);
    assign w_colon    = (i_ch == CH_COLON);
    assign w_digit    = hex_digit(i_ch);
    assign w_byte     = {r_nib, w_digit};
    assign w_idx      = r_dpos[DPOS_W-1:1];
    assign w_data_end = {1'b0, r_len} + BIDX_W'(4);
    assign w_didx     = w_idx - BIDX_W'(4);
    assign w_in_data  = (r_mode == LM_RECORD) && (w_idx >= BIDX_W'(4))
                        && (w_idx < w_data_end);

    // data beats must not overwrite the store while the back end drains it
    assign o_full = i_q_status.full || (i_store_busy && w_in_data);
    assign w_acc  = i_push && !o_full;

    assign w_byte_done = w_acc && (r_mode == LM_RECORD) && !w_eol && r_dpos[0];
    assign w_len_bad   = ({1'b0, w_byte} > MAX_LEN);
    assign w_is_cks    = (w_idx >= w_data_end);
    assign w_calc      = 8'(~r_sum + 8'd1);

    always_comb begin
        n_mode = r_mode;
        if (w_acc) begin
            case (r_mode)
                LM_START: begin
                    if (w_colon) begin
                        n_mode = LM_RECORD;
                    end else if (!w_eol) begin
                        n_mode = LM_SKIP;
                    end
                end
                LM_SKIP: begin
                    if (w_eol) begin
                        n_mode = LM_START;
                    end
                end
                LM_RECORD: begin
                    if (w_eol) begin
                        n_mode = LM_HALT;
                    end else if (r_dpos[0]) begin
                        if (w_idx == BIDX_W'(0)) begin
                            if (w_len_bad) begin
                                n_mode = LM_HALT;
                            end
                        end else if (w_is_cks) begin
                            if (w_calc != w_byte || r_type == REC_EOF) begin
                                n_mode = LM_HALT;
                            end else begin
                                n_mode = LM_SKIP;
                            end
                        end
                    end
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    always_comb begin
        n_dpos    = r_dpos;
        n_nib     = r_nib;
        n_len     = r_len;
        n_off     = r_off;
        n_type    = r_type;
        n_sum     = r_sum;
        n_upper   = r_upper;
        n_ub0     = r_ub0;
        n_ub1     = r_ub1;
        o_q_push  = 1'b0;
        o_job     = '{kind: KIND_FORMAT, addr: 32'd0, count: 8'd0, csum: 8'd0};
        o_wr_en   = 1'b0;
        o_wr_addr = w_didx[AW-1:0];
        o_wr_data = w_byte;

        if (w_acc && r_mode == LM_START && w_colon) begin
            n_dpos = '0;
            n_nib  = 4'd0;
            n_len  = 8'd0;
            n_off  = 16'd0;
            n_type = 8'd0;
            n_sum  = 8'd0;
            n_ub0  = 8'd0;
            n_ub1  = 8'd0;
        end

        if (w_acc && r_mode == LM_RECORD) begin
            if (w_eol) begin
                o_q_push = 1'b1;
            end else begin
                n_dpos = r_dpos + DPOS_W'(1);
                if (!r_dpos[0]) begin
                    n_nib = w_digit;
                end
            end
        end

        if (w_byte_done) begin
            if (!w_is_cks) begin
                n_sum = r_sum + w_byte;
            end
            if (w_idx == BIDX_W'(0)) begin
                n_len = w_byte;
                if (w_len_bad) begin
                    o_q_push = 1'b1;
                end
            end else if (w_idx == BIDX_W'(1)) begin
                n_off = {w_byte, 8'd0};
            end else if (w_idx == BIDX_W'(2)) begin
                n_off = {r_off[15:8], w_byte};
            end else if (w_idx == BIDX_W'(3)) begin
                n_type = w_byte;
            end else if (!w_is_cks) begin
                o_wr_en = 1'b1;
                if (w_didx == BIDX_W'(0)) begin
                    n_ub0 = w_byte;
                end
                if (w_didx == BIDX_W'(1)) begin
                    n_ub1 = w_byte;
                end
            end else begin
                if (w_calc != w_byte) begin
                    o_q_push  = 1'b1;
                    o_job.kind = KIND_CSUM;
                    o_job.csum = w_calc;
                end else if (r_type == REC_DATA) begin
                    o_q_push    = 1'b1;
                    o_job.kind  = (r_len == 8'd0) ? KIND_EMPTY : KIND_DATA;
                    o_job.addr  = {r_upper, 16'd0} + {16'd0, r_off};
                    o_job.count = r_len;
                end else if (r_type == REC_EOF) begin
                    o_q_push   = 1'b1;
                    o_job.kind = KIND_EOF;
                end else if (r_type == REC_EXT_LIN) begin
                    n_upper = {r_ub0, r_ub1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LM_START;
            r_dpos  <= '0;
            r_nib   <= 4'd0;
            r_len   <= 8'd0;
            r_off   <= 16'd0;
            r_type  <= 8'd0;
            r_sum   <= 8'd0;
            r_upper <= 16'd0;
            r_ub0   <= 8'd0;
            r_ub1   <= 8'd0;
        end else begin
            r_mode  <= n_mode;
            r_dpos  <= n_dpos;
            r_nib   <= n_nib;
            r_len   <= n_len;
            r_off   <= n_off;
            r_type  <= n_type;
            r_sum   <= n_sum;
            r_upper <= n_upper;
            r_ub0   <= n_ub0;
            r_ub1   <= n_ub1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ihex_back.sv
`default_nettype none

module ihex_back
    import ihex_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_queue_status                   i_q_status,
    input  wire t_job                            i_job,
    output logic                                 o_q_pop,
    input  wire logic                            i_wr_en,
    input  wire logic [$clog2(RECORD_BYTES)-1:0] i_wr_addr,
    input  wire logic [7:0]                      i_wr_data,
    output logic                                 o_busy,
    input  wire logic                            i_pop,
    output logic                                 o_empty,
    output logic [2:0]                           o_kind,
    output logic [31:0]                          o_byte_address,
    output logic [7:0]                           o_data_byte,
    output logic [7:0]                           o_checksum_calc,
    output logic                                 o_last
);

    localparam int unsigned AW = $clog2(RECORD_BYTES);
    localparam int unsigned LW = $clog2(RECORD_BYTES + 1);

    logic [7:0]  r_mem [RECORD_BYTES];
    logic [7:0]  r_rdata;

    t_back_state r_state;
    t_back_state n_state;
    logic [LW-1:0] r_idx;
    logic [LW-1:0] n_idx;
    logic [LW-1:0] r_count;
    logic [LW-1:0] n_count;
    logic [31:0] r_base;
    logic [31:0] n_base;

    logic        r_valid;
    t_kind       r_kind;
    logic [31:0] r_addr;
    logic [7:0]  r_data;
    logic [7:0]  r_csum;
    logic        r_last;

    logic        w_out_free;
    logic        w_is_last;
    logic        w_load;
    t_kind       w_kind;
    logic [31:0] w_addr;
    logic [7:0]  w_data;
    logic [7:0]  w_csum;
    logic        w_last;

    assign w_out_free = !r_valid || i_pop;
    assign w_is_last  = (r_idx == LW'(r_count - LW'(1)));
    assign o_busy     = (r_state != BK_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty && i_job.kind == KIND_DATA) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: n_state = BK_EMIT;
            BK_EMIT: begin
                if (w_out_free) begin
                    n_state = w_is_last ? BK_IDLE : BK_READ;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        w_load  = 1'b0;
        w_kind  = i_job.kind;
        w_addr  = i_job.addr;
        w_data  = 8'd0;
        w_csum  = i_job.csum;
        w_last  = 1'b1;
        n_idx   = r_idx;
        n_count = r_count;
        n_base  = r_base;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_job.kind == KIND_DATA) begin
                        o_q_pop = 1'b1;
                        n_idx   = '0;
                        n_count = LW'(i_job.count);
                        n_base  = i_job.addr;
                    end else if (w_out_free) begin
                        o_q_pop = 1'b1;
                        w_load  = 1'b1;
                    end
                end
            end
            BK_EMIT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    w_kind = KIND_DATA;
                    w_addr = r_base + 32'(r_idx);
                    w_data = r_rdata;
                    w_csum = 8'd0;
                    w_last = w_is_last;
                    n_idx  = r_idx + LW'(1);
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_count <= n_count;
        r_base  <= n_base;
        if (w_load) begin
            r_kind <= w_kind;
            r_addr <= w_addr;
            r_data <= w_data;
            r_csum <= w_csum;
            r_last <= w_last;
        end
    end

    assign o_empty         = !r_valid;
    assign o_kind          = r_kind;
    assign o_byte_address  = r_addr;
    assign o_data_byte     = r_data;
    assign o_checksum_calc = r_csum;
    assign o_last          = r_last;

endmodule

`default_nettype wire

// File: rtl/intel_hex_record_parser.sv
`default_nettype none

// channel   | handshake          | beat
// ----------+--------------------+--------------------------------------------
// text in   | push / full        | i_ch
// result out| pop / empty        | o_kind o_byte_address o_data_byte
//           |                    | o_checksum_calc o_last
//
// The front end takes one character per cycle while full is low. Each data
// byte of a record leaves the back end through a read state and an emit
// state, as the record store read is registered; other results load once queued.
// Header and checksum characters of the next record keep flowing while the
// back end drains; data characters stall (full) until the store is free.
// Synchronous active-low reset; the record store is not cleared.

module intel_hex_record_parser
    import ihex_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_ch,
    input  wire logic        pop,
    output logic             empty,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_byte_address,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_checksum_calc,
    output logic             o_last
);

    localparam int unsigned AW = $clog2(RECORD_BYTES);

    t_queue_status   w_q_status;
    t_job            w_push_job;
    t_job            w_pop_job;
    logic            w_q_push;
    logic            w_q_pop;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    logic [7:0]      w_wr_data;
    logic            w_back_busy;
    logic            w_store_busy;

    assign w_store_busy = !w_q_status.empty || w_back_busy;

    ihex_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_ch         (i_ch),
        .i_q_status   (w_q_status),
        .i_store_busy (w_store_busy),
        .o_full       (full),
        .o_q_push     (w_q_push),
        .o_job        (w_push_job),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data)
    );

    ihex_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_job    (w_push_job),
        .i_pop    (w_q_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    ihex_back #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (w_q_status),
        .i_job           (w_pop_job),
        .o_q_pop         (w_q_pop),
        .i_wr_en         (w_wr_en),
        .i_wr_addr       (w_wr_addr),
        .i_wr_data       (w_wr_data),
        .o_busy          (w_back_busy),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_byte_address  (o_byte_address),
        .o_data_byte     (o_data_byte),
        .o_checksum_calc (o_checksum_calc),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
